>>> rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

>>> rtl/mmcs_pkg.sv
package mmcs_pkg;

  localparam int FRAME_PIXELS = 4096;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int PIX_W        = 16;
  localparam int OUT_W        = 8;
  localparam int NUM_W        = PIX_W + OUT_W;
  localparam int STEP_W       = $clog2(OUT_W);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_CLOSED = 2'd1,
    ST_FULL       = 2'd2,
    ST_PAST_END   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bk_state_t;

  // One classified item on its way to the back end.
  typedef struct packed {
    logic             is_read;
    status_t          status;
    logic             last;
    logic             div;
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] span;
  } qent_t;

endpackage

>>> rtl/mmcs_if.sv
interface mmcs_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] pixel_in;
  logic        last_in;

  modport source(output valid, operation, pixel_in, last_in, input ready);
  modport sink(input valid, operation, pixel_in, last_in, output ready);
endinterface

interface mmcs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       last_out;
  logic [1:0] status;
  logic       is_read_result;

  modport source(output valid, pixel_out, last_out, status, is_read_result, input ready);
  modport sink(input valid, pixel_out, last_out, status, is_read_result, output ready);
endinterface

>>> rtl/minmax_contrast_stretch_16to8_top.sv
// A load passes the front stage register, the queue and the output register; a good read
// also passes the divider. Loads, flagged reads and dropped loads go one item per cycle
// when not stalled; a good read holds the back end for the 8-step bit-serial divider.
// Reset is synchronous and clears control state only; the frame store is never cleared,
// so no clearing pass follows reset and items are taken on the first cycle after it.
`include "assert_macros.svh"

module minmax_contrast_stretch_16to8_top (
  input  logic       clk,
  input  logic       rst,
  mmcs_req_if.sink   req,
  mmcs_rsp_if.source rsp
);
  import mmcs_pkg::*;

  qent_t push_entry;
  qent_t pop_entry;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  mmcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_entry (push_entry),
    .q_push  (q_push),
    .q_full  (q_full)
  );

  mmcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .nonempty   (q_valid)
  );

  mmcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (pop_entry),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

  `ASSERT_NEVER(a_no_push_full, clk, rst, q_push && q_full)
  `ASSERT_NEVER(a_no_pop_empty, clk, rst, q_pop && !q_valid)
  `ASSERT_CHK(a_err_zero, clk, rst, (rsp.valid && rsp.status != ST_OK) |-> (rsp.pixel_out == '0 && !rsp.last_out))
  `ASSERT_CHK(a_load_ack, clk, rst, (rsp.valid && !rsp.is_read_result) |-> (rsp.status == ST_OK || rsp.status == ST_FULL))

endmodule

>>> rtl/mmcs_front.sv
module mmcs_front (
  input  logic           clk,
  input  logic           rst,
  mmcs_req_if.sink       req,
  output mmcs_pkg::qent_t q_entry,
  output logic           q_push,
  input  logic           q_full
);
  import mmcs_pkg::*;

  logic [PIX_W-1:0] mem [FRAME_PIXELS];
  logic [PIX_W-1:0] rd_data;

  logic [PIX_W-1:0] run_min;
  logic [PIX_W-1:0] run_max;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rptr;
  logic             closed;

  logic             s1_valid;
  logic             s1_read;
  status_t          s1_status;
  logic             s1_last;
  logic             s1_fetch;
  logic [PIX_W-1:0] s1_min;
  logic [PIX_W-1:0] s1_max;

  logic             accept;
  logic             is_read;
  logic [CNT_W-1:0] base_cnt;
  logic [PIX_W-1:0] base_min;
  logic [PIX_W-1:0] base_max;
  logic             full;
  logic             rd_ok;
  logic             wr_en;
  logic             fetch;
  status_t          status_next;
  logic [PIX_W:0]   diff;
  logic [PIX_W-1:0] d;
  logic             flat;

  assign req.ready = !s1_valid || !q_full;
  assign accept    = req.valid && req.ready;
  assign is_read   = (req.operation == OP_READ);

  always_comb begin
    // a load after a closed frame starts from a clean frame
    base_cnt = closed ? '0 : cnt;
    base_min = closed ? '1 : run_min;
    base_max = closed ? '0 : run_max;
    full     = (base_cnt == CNT_W'(FRAME_PIXELS));
    rd_ok    = closed && (rptr < cnt);
    wr_en    = accept && !is_read && !full;
    fetch    = accept && is_read && rd_ok;
    if (!is_read) begin
      status_next = full ? ST_FULL : ST_OK;
    end else if (!closed) begin
      status_next = ST_NOT_CLOSED;
    end else if (!rd_ok) begin
      status_next = ST_PAST_END;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '1;
      run_max <= '0;
      cnt     <= '0;
      rptr    <= '0;
      closed  <= 1'b0;
    end else if (accept) begin
      if (!is_read) begin
        cnt     <= full ? base_cnt : base_cnt + CNT_W'(1);
        rptr    <= closed ? '0 : rptr;
        run_min <= (!full && req.pixel_in < base_min) ? req.pixel_in : base_min;
        run_max <= (!full && req.pixel_in > base_max) ? req.pixel_in : base_max;
        closed  <= req.last_in;
      end else if (rd_ok) begin
        rptr <= rptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[base_cnt[ADDR_W-1:0]] <= req.pixel_in;
    end
    if (fetch) begin
      rd_data <= mem[rptr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read   <= is_read;
      s1_status <= status_next;
      s1_last   <= fetch && (rptr + CNT_W'(1) == cnt);
      s1_fetch  <= fetch;
      s1_min    <= run_min;
      s1_max    <= run_max;
    end
  end

  // scale the offset by 255 and hand the numerator and span over to the back end
  always_comb begin
    diff             = {1'b0, rd_data} - {1'b0, s1_min};
    d                = diff[PIX_W-1:0];
    flat             = (s1_max <= s1_min);
    q_push           = s1_valid && !q_full;
    q_entry.is_read  = s1_read;
    q_entry.status   = s1_status;
    q_entry.last     = s1_last;
    q_entry.div      = s1_fetch && !flat && !diff[PIX_W];
    q_entry.num      = {d, OUT_W'(0)} - {OUT_W'(0), d};
    q_entry.span     = s1_max - s1_min;
  end

endmodule

>>> rtl/mmcs_queue.sv
module mmcs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mmcs_pkg::qent_t push_entry,
  output logic            full,
  input  logic            pop,
  output mmcs_pkg::qent_t pop_entry,
  output logic            nonempty
);
  import mmcs_pkg::*;

  qent_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W + 1)'(QDEPTH));
  assign nonempty  = (count != '0);
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

>>> rtl/mmcs_back.sv
module mmcs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mmcs_pkg::qent_t q_entry,
  output logic            q_pop,
  mmcs_rsp_if.source      rsp
);
  import mmcs_pkg::*;

  bk_state_t         state;
  bk_state_t         state_next;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [OUT_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              last_r;

  logic              ov;
  logic [OUT_W-1:0]  o_pix;
  logic              o_last;
  status_t           o_status;
  logic              o_read;

  logic              out_free;
  logic              start_div;
  logic              load_direct;
  logic              load_quo;
  logic              ge;

  assign out_free = !ov || rsp.ready;
  assign ge       = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    start_div   = 1'b0;
    load_direct = 1'b0;
    load_quo    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_entry.div) begin
            q_pop      = 1'b1;
            start_div  = 1'b1;
            state_next = BK_DIV;
          end else if (out_free) begin
            q_pop       = 1'b1;
            load_direct = 1'b1;
          end
        end
      end
      BK_DIV: begin
        if (step == '0) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_quo   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // restoring divide, one quotient bit per cycle; quotient is known to fit OUT_W bits
  always_ff @(posedge clk) begin
    if (start_div) begin
      rem    <= q_entry.num;
      dsh    <= {1'b0, q_entry.span, (OUT_W - 1)'(0)};
      quo    <= '0;
      step   <= STEP_W'(OUT_W - 1);
      last_r <= q_entry.last;
    end else if (state == BK_DIV) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[OUT_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_direct || load_quo) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      o_pix    <= '0;
      o_last   <= q_entry.last;
      o_status <= q_entry.status;
      o_read   <= q_entry.is_read;
    end else if (load_quo) begin
      o_pix    <= quo;
      o_last   <= last_r;
      o_status <= ST_OK;
      o_read   <= 1'b1;
    end
  end

  assign rsp.valid          = ov;
  assign rsp.pixel_out      = o_pix;
  assign rsp.last_out       = o_last;
  assign rsp.status         = o_status;
  assign rsp.is_read_result = o_read;

endmodule

>>> tb/mmcs_stretch_checker.sv
`timescale 1ns / 1ps

module mmcs_stretch_checker
  import mmcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mmcs_req_if  req,
  mmcs_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned FULL_SCALE = (1 << OUT_W) - 1;

  typedef struct packed {
    logic [OUT_W-1:0] pixel;
    logic             last;
    status_t          status;
    logic             is_read;
  } stretch_result_t;

  stretch_result_t  expected_q[$];

  // Own copy of the frame and its statistics.
  logic [PIX_W-1:0] frame_mem[FRAME_PIXELS];
  logic [PIX_W-1:0] frame_lo;
  logic [PIX_W-1:0] frame_hi;
  int unsigned      stored_cnt;
  int unsigned      read_idx;
  logic             closed;
  int               mismatches = 0;

  function automatic stretch_result_t stretch_item(input op_t op,
                                                   input logic [PIX_W-1:0] pix,
                                                   input logic last);
    stretch_result_t res;
    int unsigned     pix_ext;
    int unsigned     span;
    res.pixel   = '0;
    res.last    = 1'b0;
    res.status  = ST_OK;
    res.is_read = 1'b0;
    if (op == OP_LOAD) begin
      // A load after a closed frame starts a fresh one.
      if (closed) begin
        stored_cnt = 0;
        read_idx   = 0;
        frame_lo   = '1;
        frame_hi   = '0;
        closed     = 1'b0;
      end
      if (stored_cnt >= FRAME_PIXELS) begin
        res.status = ST_FULL;
      end else begin
        frame_mem[stored_cnt] = pix;
        stored_cnt++;
        if (pix < frame_lo) frame_lo = pix;
        if (pix > frame_hi) frame_hi = pix;
      end
      if (last) closed = 1'b1;
    end else begin
      res.is_read = 1'b1;
      if (!closed) begin
        res.status = ST_NOT_CLOSED;
      end else if (read_idx >= stored_cnt) begin
        res.status = ST_PAST_END;
      end else begin
        if (frame_hi > frame_lo) begin
          pix_ext   = frame_mem[read_idx];
          span      = int'(frame_hi) - int'(frame_lo);
          res.pixel = OUT_W'(((pix_ext - frame_lo) * FULL_SCALE) / span);
        end
        res.last = (read_idx + 1 == stored_cnt);
        read_idx++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    stretch_result_t want;
    if (rst) begin
      expected_q.delete();
      stored_cnt = 0;
      read_idx   = 0;
      frame_lo   = '1;
      frame_hi   = '0;
      closed     = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing outstanding");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, rsp.pixel_out);
            mismatches++;
          end
          if (rsp.last_out !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, rsp.last_out);
            mismatches++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.is_read_result !== want.is_read) begin
            $error("is_read_result: expected %0d, got %0d", want.is_read,
                   rsp.is_read_result);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_q.push_back(stretch_item(op_t'(req.operation), req.pixel_in, req.last_in));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

>>> tb/tb_minmax_contrast_stretch_16to8_top.sv
`timescale 1ns / 1ps

module tb_minmax_contrast_stretch_16to8_top;
  import mmcs_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    PIX_RANDOM,
    PIX_NARROW,
    PIX_FLAT,
    PIX_EXTREME
  } pix_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   hold_token  = 0;
  int   steady_left = 0;
  int   items_sent  = 0;

  mmcs_req_if req_ch();
  mmcs_rsp_if rsp_ch();

  minmax_contrast_stretch_16to8_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mmcs_stretch_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      steady_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input op_t op, input logic [PIX_W-1:0] pix, input logic last);
    int   gap;
    logic took;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.pixel_in  <= pix;
    req_ch.last_in   <= last;
    // Sample ready mid-cycle, when everything driven at the edge has settled.
    do begin
      @(negedge clk);
      took = req_ch.ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic send_read();
    send_item(OP_READ, 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_frame(input int size, input pix_style_t style, input bit noisy);
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] pix;
    int               spread;
    int               reads;
    spread = $urandom_range(1, 300);
    base   = (style == PIX_NARROW) ? 16'($urandom_range(0, 65535 - spread)) : 16'($urandom);
    for (int i = 0; i < size; i++) begin
      case (style)
        PIX_RANDOM: pix = 16'($urandom);
        PIX_NARROW: pix = 16'(base + $urandom_range(0, spread));
        PIX_FLAT:   pix = base;
        default: begin
          case ($urandom_range(0, 3))
            0:       pix = '0;
            1:       pix = '1;
            2:       pix = 16'd1;
            default: pix = 16'hFFFE;
          endcase
        end
      endcase
      if (noisy && $urandom_range(0, 7) == 0) send_read();
      send_item(OP_LOAD, pix, i == size - 1);
    end
    reads = size;
    if (noisy) begin
      if ($urandom_range(0, 1)) reads = size + $urandom_range(1, 3);
      else reads = $urandom_range(0, size - 1);
    end else if ($urandom_range(0, 4) == 0) begin
      reads = size + 1;
    end
    repeat (reads) send_read();
  endtask

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    int seen_hold;
    int stall_left;
    int r;
    seen_hold  = 0;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= (stall_left < 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_ch.ready <= 1'b1;
        end else if (r < 71) begin
          // Long stretch with ready held high.
          rsp_ch.ready <= 1'b1;
          repeat (100) @(posedge clk);
        end else begin
          rsp_ch.ready <= 1'b0;
          if (r < 96) stall_left = $urandom_range(0, 2);
          else if (r < 99) stall_left = $urandom_range(4, 14);
          else stall_left = $urandom_range(19, 39);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int frames;
    int random_start;
    int r;
    int size;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_LOAD;
    req_ch.pixel_in  <= '0;
    req_ch.last_in   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Read before anything was loaded.
    send_read();
    // Extreme pixels, with a read while the frame is still open.
    send_item(OP_LOAD, 16'd0, 1'b0);
    send_item(OP_LOAD, 16'hFFFF, 1'b0);
    send_read();
    send_item(OP_LOAD, 16'd1234, 1'b1);
    repeat (4) send_read();
    // Single-pixel frame is flat; then read past the end.
    send_item(OP_LOAD, 16'd7, 1'b1);
    repeat (2) send_read();
    // Flat frame of two equal pixels.
    send_item(OP_LOAD, 16'd500, 1'b0);
    send_item(OP_LOAD, 16'd500, 1'b1);
    repeat (2) send_read();
    // Span of one at the top of the range.
    send_item(OP_LOAD, 16'hFFFF, 1'b0);
    send_item(OP_LOAD, 16'hFFFE, 1'b1);
    repeat (2) send_read();
    // New frame while the old one is only partly read.
    send_item(OP_LOAD, 16'd100, 1'b0);
    send_item(OP_LOAD, 16'd200, 1'b1);
    send_read();
    send_item(OP_LOAD, 16'd300, 1'b1);
    repeat (2) send_read();
    wait_drain();

    frames       = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (frames == 3) begin
        // Hold off the response side while loads keep coming.
        hold_token <= hold_token + 1;
        run_frame(40, PIX_RANDOM, 1'b0);
      end else begin
        if ($urandom_range(0, 29) == 0) wait_drain();
        r = $urandom_range(0, 99);
        if (r < 80) size = $urandom_range(1, 12);
        else if (r < 97) size = $urandom_range(13, 48);
        else size = $urandom_range(49, 200);
        run_frame(size, pix_style_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      end
      frames++;
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
